>>> rtl/pst_pkg.sv
package pst_pkg;

	// fixed field widths
	localparam int unsigned POS_W      = 32;
	localparam int unsigned DIFF_W     = 33;
	localparam int unsigned SPEED_W    = 24;
	localparam int unsigned TSTEP_W    = 16;
	localparam int unsigned STEP_W     = 25;
	localparam int unsigned HEAD_W     = 16;
	localparam int unsigned RAD_W      = 66;
	localparam int unsigned ROOT_W     = 33;
	localparam int unsigned SQREM_W    = 35;
	localparam int unsigned NUM_W      = 59;
	localparam int unsigned CX_W       = 45;
	localparam int unsigned Z_W        = 28;
	localparam int unsigned CNT_W      = 6;
	localparam int unsigned ATAN_IDX_W = 5;
	localparam int unsigned ATAN_LEN   = 24;

	// last loop-counter values of the root and divide loops
	localparam logic [CNT_W-1:0] ROOT_LAST = 6'd32;
	localparam logic [CNT_W-1:0] DIV_LAST  = 6'd32;

	// angle constants, Q24 radians and Q3.13 radians
	localparam logic signed [Z_W-1:0]    PI_Q24   = 28'sd52707179;
	localparam logic [HEAD_W:0]          HEAD_MAX = 17'd25736;
	localparam int unsigned              HEAD_SH  = 11;
	localparam logic [Z_W-1:0]           HEAD_RND = 28'd1024;

	// step rounding
	localparam int unsigned TS_FRAC = 16;

	// configuration register indexes and reset values
	localparam logic REG_SPEED = 1'b0;
	localparam logic REG_TSTEP = 1'b1;
	localparam logic [SPEED_W-1:0] SPEED_RST = 24'd32768;
	localparam logic [TSTEP_W-1:0] TSTEP_RST = 16'd3277;

	localparam int unsigned CORDIC_STEPS_DEF = 16;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQ_X,
		S_SQ_Y,
		S_ROOT,
		S_DIVINIT,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             load;
		logic             sq_x;
		logic             sq_y;
		logic             root_step;
		logic             cordic_step;
		logic             div_init;
		logic             div_step;
		logic             commit;
		logic [CNT_W-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic snap;
		logic out_free;
	} sts_t;

	// arctangent of 2^-i in Q24 radians
	function automatic logic [Z_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
		logic [Z_W-1:0] v;
		case (idx)
			5'd0:  v = 28'd13176795;
			5'd1:  v = 28'd7778716;
			5'd2:  v = 28'd4110060;
			5'd3:  v = 28'd2086331;
			5'd4:  v = 28'd1047214;
			5'd5:  v = 28'd524117;
			5'd6:  v = 28'd262123;
			5'd7:  v = 28'd131069;
			5'd8:  v = 28'd65536;
			5'd9:  v = 28'd32768;
			5'd10: v = 28'd16384;
			5'd11: v = 28'd8192;
			5'd12: v = 28'd4096;
			5'd13: v = 28'd2048;
			5'd14: v = 28'd1024;
			5'd15: v = 28'd512;
			5'd16: v = 28'd256;
			5'd17: v = 28'd128;
			5'd18: v = 28'd64;
			5'd19: v = 28'd32;
			5'd20: v = 28'd16;
			5'd21: v = 28'd8;
			5'd22: v = 28'd4;
			5'd23: v = 28'd2;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/pst_ctrl.sv
module pst_ctrl #(
	parameter int unsigned CORDIC_STEPS = pst_pkg::CORDIC_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pst_pkg::sts_t sts,
	output pst_pkg::cmd_t cmd
);

	pst_pkg::state_t state_q, state_d;
	logic [pst_pkg::CNT_W-1:0] cnt_q;

	// state register and loop counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pst_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q)
				cnt_q <= '0;
			else if (state_q == pst_pkg::S_ROOT || state_q == pst_pkg::S_DIV)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pst_pkg::S_IDLE:    if (in_valid) state_d = pst_pkg::S_SQ_X;
			pst_pkg::S_SQ_X:    state_d = sts.zero ? pst_pkg::S_DONE : pst_pkg::S_SQ_Y;
			pst_pkg::S_SQ_Y:    state_d = pst_pkg::S_ROOT;
			pst_pkg::S_ROOT:    if (cnt_q == pst_pkg::ROOT_LAST) state_d = pst_pkg::S_DIVINIT;
			pst_pkg::S_DIVINIT: state_d = sts.snap ? pst_pkg::S_DONE : pst_pkg::S_DIV;
			pst_pkg::S_DIV:     if (cnt_q == pst_pkg::DIV_LAST) state_d = pst_pkg::S_DONE;
			pst_pkg::S_DONE:    if (sts.out_free) state_d = pst_pkg::S_IDLE;
			default:            state_d = pst_pkg::S_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		in_ready        = (state_q == pst_pkg::S_IDLE);
		cmd             = '0;
		cmd.cnt         = cnt_q;
		cmd.load        = (state_q == pst_pkg::S_IDLE) && in_valid;
		cmd.sq_x        = (state_q == pst_pkg::S_SQ_X);
		cmd.sq_y        = (state_q == pst_pkg::S_SQ_Y);
		cmd.root_step   = (state_q == pst_pkg::S_ROOT);
		cmd.cordic_step = (state_q == pst_pkg::S_ROOT) &&
			(32'(cnt_q) < CORDIC_STEPS);
		cmd.div_init    = (state_q == pst_pkg::S_DIVINIT);
		cmd.div_step    = (state_q == pst_pkg::S_DIV);
		cmd.commit      = (state_q == pst_pkg::S_DONE) && sts.out_free;
	end

	// loop counter stays within the longest loop
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pst_pkg::ROOT_LAST)
		else $error("loop counter overrun");

	// a beat is taken only with the machine idle, and it starts work
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == pst_pkg::S_SQ_X)
		else $error("load did not start work");

	// commit returns to idle
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == pst_pkg::S_IDLE)
		else $error("commit did not return to idle");

endmodule

>>> rtl/pst_dp.sv
module pst_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic                                    cfg_index,
	input  logic [pst_pkg::SPEED_W-1:0]             cfg_data,
	input  logic signed [pst_pkg::POS_W-1:0]        goal_x,
	input  logic signed [pst_pkg::POS_W-1:0]        goal_y,
	input  pst_pkg::cmd_t                           cmd,
	output pst_pkg::sts_t                           sts,
	input  logic                                    out_ready,
	output logic                                    out_valid,
	output logic signed [pst_pkg::POS_W-1:0]        pos_x,
	output logic signed [pst_pkg::POS_W-1:0]        pos_y,
	output logic signed [pst_pkg::HEAD_W-1:0]       heading,
	output logic [pst_pkg::POS_W-1:0]               remaining,
	output logic                                    arrived
);

	localparam int unsigned PW = pst_pkg::POS_W;
	localparam int unsigned DW = pst_pkg::DIFF_W;
	localparam int unsigned RW = pst_pkg::ROOT_W;

	logic [pst_pkg::SPEED_W-1:0] speed_q;
	logic [pst_pkg::TSTEP_W-1:0] tstep_q;

	logic signed [PW-1:0] cur_x_q, cur_y_q, tx_q, ty_q;
	logic signed [pst_pkg::HEAD_W-1:0] cur_head_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic [pst_pkg::STEP_W-1:0] step_q;

	logic [pst_pkg::RAD_W-1:0]   rad_q;
	logic [pst_pkg::SQREM_W-1:0] sqrem_q;
	logic [RW-1:0]               root_q;

	logic signed [pst_pkg::CX_W-1:0] cx_q, cy_q;
	logic signed [pst_pkg::Z_W-1:0]  cz_q;

	logic [RW-1:0] rx_q, ry_q, qx_q, qy_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= pst_pkg::SPEED_RST;
			tstep_q <= pst_pkg::TSTEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pst_pkg::REG_SPEED: speed_q <= cfg_data;
				pst_pkg::REG_TSTEP: tstep_q <= cfg_data[pst_pkg::TSTEP_W-1:0];
				default: ;
			endcase
		end
	end

	// offsets and step length
	logic [DW-1:0] ax, ay;
	logic [40:0]   step_full;
	assign ax = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
	assign ay = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
	assign step_full = 41'(speed_q * tstep_q) + 41'(1 << (pst_pkg::TS_FRAC - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tx_q   <= goal_x;
			ty_q   <= goal_y;
			dx_q   <= DW'(goal_x) - DW'(cur_x_q);
			dy_q   <= DW'(goal_y) - DW'(cur_y_q);
			step_q <= step_full[pst_pkg::TS_FRAC +: pst_pkg::STEP_W];
		end
	end

	// sum of squares, then bit-pair square root
	logic [pst_pkg::SQREM_W+1:0] sq_t, sq_trial;
	assign sq_t     = {sqrem_q, rad_q[pst_pkg::RAD_W-1 -: 2]};
	assign sq_trial = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.sq_x) begin
			rad_q <= pst_pkg::RAD_W'(ax * ax);
		end else if (cmd.sq_y) begin
			rad_q   <= rad_q + pst_pkg::RAD_W'(ay * ay);
			sqrem_q <= '0;
			root_q  <= '0;
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[pst_pkg::RAD_W-3:0], 2'b00};
			if (sq_t >= sq_trial) begin
				sqrem_q <= pst_pkg::SQREM_W'(sq_t - sq_trial);
				root_q  <= {root_q[RW-2:0], 1'b1};
			end else begin
				sqrem_q <= pst_pkg::SQREM_W'(sq_t);
				root_q  <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	// cordic vectoring for the heading
	logic signed [pst_pkg::CX_W-1:0] cx0, cy0, xs, ys;
	logic [pst_pkg::ATAN_IDX_W-1:0]  ci;
	logic signed [pst_pkg::Z_W-1:0]  at;
	assign cx0 = {{4{dx_q[DW-1]}}, dx_q, 8'b0};
	assign cy0 = {{4{dy_q[DW-1]}}, dy_q, 8'b0};
	assign ci  = cmd.cnt[pst_pkg::ATAN_IDX_W-1:0];
	assign xs  = cx_q >>> ci;
	assign ys  = cy_q >>> ci;
	assign at  = pst_pkg::atan_q24(ci);

	always_ff @(posedge clk) begin
		if (cmd.sq_x) begin
			if (cx0 < 0) begin
				cx_q <= -cx0;
				cy_q <= -cy0;
				cz_q <= (cy0 >= 0) ? pst_pkg::PI_Q24 : -pst_pkg::PI_Q24;
			end else begin
				cx_q <= cx0;
				cy_q <= cy0;
				cz_q <= '0;
			end
		end else if (cmd.cordic_step) begin
			if (cy_q >= 0) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + at;
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - at;
			end
		end
	end

	// two restoring dividers for the per-axis moves
	logic [pst_pkg::NUM_W-1:0] numx, numy;
	logic [RW:0] tdx, tdy;
	logic gex, gey;
	assign numx = pst_pkg::NUM_W'(ax * step_q) + pst_pkg::NUM_W'(root_q >> 1);
	assign numy = pst_pkg::NUM_W'(ay * step_q) + pst_pkg::NUM_W'(root_q >> 1);
	assign tdx  = {rx_q, qx_q[RW-1]};
	assign tdy  = {ry_q, qy_q[RW-1]};
	assign gex  = tdx >= {1'b0, root_q};
	assign gey  = tdy >= {1'b0, root_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rx_q <= RW'(numx[pst_pkg::NUM_W-1:RW]);
			ry_q <= RW'(numy[pst_pkg::NUM_W-1:RW]);
			qx_q <= numx[RW-1:0];
			qy_q <= numy[RW-1:0];
		end else if (cmd.div_step) begin
			rx_q <= gex ? RW'(tdx - {1'b0, root_q}) : tdx[RW-1:0];
			ry_q <= gey ? RW'(tdy - {1'b0, root_q}) : tdy[RW-1:0];
			qx_q <= {qx_q[RW-2:0], gex};
			qy_q <= {qy_q[RW-2:0], gey};
		end
	end

	// status to the controller
	assign sts.zero     = (dx_q == '0) && (dy_q == '0);
	assign sts.snap     = {8'b0, step_q} >= root_q;
	assign sts.out_free = !out_valid || out_ready;

	// heading rounding and clamp
	logic [pst_pkg::Z_W-1:0]    zmag;
	logic [pst_pkg::HEAD_W:0]   hq, hcl;
	logic signed [pst_pkg::HEAD_W-1:0] head_new;
	assign zmag     = cz_q[pst_pkg::Z_W-1] ? pst_pkg::Z_W'(-cz_q) : pst_pkg::Z_W'(cz_q);
	assign hq       = (pst_pkg::HEAD_W+1)'((zmag + pst_pkg::HEAD_RND) >> pst_pkg::HEAD_SH);
	assign hcl      = (hq > pst_pkg::HEAD_MAX) ? pst_pkg::HEAD_MAX : hq;
	assign head_new = cz_q[pst_pkg::Z_W-1] ? pst_pkg::HEAD_W'(-hcl) : pst_pkg::HEAD_W'(hcl);

	// new position and remaining distance
	logic signed [PW-1:0] mvx, mvy;
	logic [RW-1:0] left;
	assign mvx  = dx_q[DW-1] ? cur_x_q - PW'(qx_q) : cur_x_q + PW'(qx_q);
	assign mvy  = dy_q[DW-1] ? cur_y_q - PW'(qy_q) : cur_y_q + PW'(qy_q);
	assign left = root_q - RW'(step_q);

	// pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			cur_head_q <= '0;
		end else if (cmd.commit && !sts.zero) begin
			cur_head_q <= head_new;
			cur_x_q    <= sts.snap ? tx_q : mvx;
			cur_y_q    <= sts.snap ? ty_q : mvy;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.commit)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (sts.zero) begin
				pos_x     <= cur_x_q;
				pos_y     <= cur_y_q;
				heading   <= cur_head_q;
				remaining <= '0;
				arrived   <= 1'b1;
			end else if (sts.snap) begin
				pos_x     <= tx_q;
				pos_y     <= ty_q;
				heading   <= head_new;
				remaining <= '0;
				arrived   <= 1'b1;
			end else begin
				pos_x     <= mvx;
				pos_y     <= mvy;
				heading   <= head_new;
				remaining <= left[RW-1] ? '1 : left[PW-1:0];
				arrived   <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/pose_step_toward_target.sv
// a step that reaches the target skips the divide; a target at the current pose also skips
// the second squaring, the root and the divide
// loop: squaring of x and then of y, 33 square-root iterations (cordic runs beside them), a divide
// setup step and 33 divide iterations; one item in flight, next beat taken after commit
// commit waits while the output register still holds a result that was not accepted
// reset: arst_n clears pose to zero, speed to 0.5 m/s, time step to 3277, output empty
module pose_step_toward_target #(
	parameter int unsigned CORDIC_STEPS = pst_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [pst_pkg::SPEED_W-1:0]   cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [63:0]                   s_tdata,   // goal_x, goal_y
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [111:0]                  m_tdata,   // pos_x, pos_y, heading, remaining
	output logic                          m_tuser    // arrived
);

	pst_pkg::cmd_t cmd;
	pst_pkg::sts_t sts;
	logic signed [31:0] pos_x, pos_y;
	logic signed [15:0] heading;
	logic [31:0]        remaining;

	pst_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pst_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.goal_x    (s_tdata[31:0]),
		.goal_y    (s_tdata[63:32]),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.heading   (heading),
		.remaining (remaining),
		.arrived   (m_tuser)
	);

	// pack result beat
	assign m_tdata = {remaining, heading, pos_y, pos_x};

	// arrived flag agrees with remaining distance
	a_arrived: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == (remaining == 32'd0)))
		else $error("arrived flag disagrees with remaining");

	// heading stays within plus or minus pi
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (heading <= 16'sd25736) && (heading >= -16'sd25736))
		else $error("heading out of range");

	// no result appears the cycle after a beat is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result too early");

endmodule

>>> tb/sv/pose_step_toward_target_test.sv
module pose_step_toward_target_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [15:0] heading;
		logic [31:0] remaining;
		logic        arrived;
	} pose_result_t;

	// pose predictor and queue of expected pose beats
	class pose_scoreboard;
		logic [pst_pkg::SPEED_W-1:0] spd;
		logic [pst_pkg::TSTEP_W-1:0] tstep;
		longint             pose_x, pose_y, pose_head;
		pose_result_t       pending_q[$];
		int                 errors;
		int                 targets_seen, results_seen, snaps, moves, stays, saturated;

		function new();
			spd = pst_pkg::SPEED_RST;
			tstep = pst_pkg::TSTEP_RST;
			pose_x = 0;
			pose_y = 0;
			pose_head = 0;
			errors = 0;
		endfunction

		function void write_reg(logic idx, logic [pst_pkg::SPEED_W-1:0] val);
			if (idx == pst_pkg::REG_SPEED)
				spd = val;
			else
				tstep = val[pst_pkg::TSTEP_W-1:0];
		endfunction

		// floor square root of a 66 bit sum of squares
		function longint unsigned floor_root(logic [65:0] v);
			longint unsigned root, rem, trial;
			root = 0;
			rem = 0;
			for (int k = 32; k >= 0; k--) begin
				rem = (rem << 2) | longint'(v[2*k +: 2]);
				trial = (root << 2) | 1;
				if (rem >= trial) begin
					rem = rem - trial;
					root = (root << 1) | 1;
				end else begin
					root = root << 1;
				end
			end
			return root;
		endfunction

		// cordic vectoring toward the offset, rounded to q3.13
		function longint course_angle(longint dx, longint dy);
			longint x, y, z, xs, ys, mag, q;
			int n;
			x = dx * 256;
			y = dy * 256;
			z = 0;
			n = (pst_pkg::CORDIC_STEPS_DEF > pst_pkg::ATAN_LEN) ?
				pst_pkg::ATAN_LEN : pst_pkg::CORDIC_STEPS_DEF;
			if (x < 0) begin
				z = (y >= 0) ? longint'(pst_pkg::PI_Q24) : -longint'(pst_pkg::PI_Q24);
				x = -x;
				y = -y;
			end
			for (int i = 0; i < n; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + longint'(pst_pkg::atan_q24(5'(i)));
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - longint'(pst_pkg::atan_q24(5'(i)));
				end
			end
			mag = (z < 0) ? -z : z;
			q = (mag + longint'(pst_pkg::HEAD_RND)) >>> pst_pkg::HEAD_SH;
			if (q > longint'(pst_pkg::HEAD_MAX))
				q = longint'(pst_pkg::HEAD_MAX);
			return (z < 0) ? -q : q;
		endfunction

		// accepted target beat: advance the pose and queue the expected result
		function void note_target(logic [31:0] tx_b, logic [31:0] ty_b);
			longint tx, ty, dx, dy;
			longint unsigned ax, ay, span, move_len, mx, my, left, rem_out;
			logic [65:0] ax66, ay66, sq;
			logic done;
			pose_result_t r;
			tx = longint'($signed(tx_b));
			ty = longint'($signed(ty_b));
			dx = tx - pose_x;
			dy = ty - pose_y;
			ax = (dx < 0) ? -dx : dx;
			ay = (dy < 0) ? -dy : dy;
			move_len = (longint'(spd) * longint'(tstep) + (1 << (pst_pkg::TS_FRAC - 1)))
				>> pst_pkg::TS_FRAC;
			rem_out = 0;
			done = 1'b1;
			targets_seen++;
			if (ax == 0 && ay == 0) begin
				stays++;
			end else begin
				ax66 = ax;
				ay66 = ay;
				sq = ax66 * ax66 + ay66 * ay66;
				span = floor_root(sq);
				pose_head = course_angle(dx, dy);
				if (move_len >= span) begin
					pose_x = tx;
					pose_y = ty;
					snaps++;
				end else begin
					mx = (ax * move_len + span / 2) / span;
					my = (ay * move_len + span / 2) / span;
					left = span - move_len;
					pose_x = pose_x + ((dx < 0) ? -longint'(mx) : longint'(mx));
					pose_y = pose_y + ((dy < 0) ? -longint'(my) : longint'(my));
					if (left > 64'hFFFF_FFFF) begin
						rem_out = 64'hFFFF_FFFF;
						saturated++;
					end else begin
						rem_out = left;
					end
					done = (rem_out == 0);
					moves++;
				end
			end
			r.pos_x = pose_x[31:0];
			r.pos_y = pose_y[31:0];
			r.heading = pose_head[15:0];
			r.remaining = rem_out[31:0];
			r.arrived = done;
			pending_q.push_back(r);
		endfunction

		// result beat against the oldest expectation
		function void check_result(logic [111:0] d, logic user);
			pose_result_t e;
			results_seen++;
			if (pending_q.size() == 0) begin
				$error("unexpected result beat: %h arrived=%0b", d, user);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (d[31:0] !== e.pos_x) begin
				$error("pos_x expected %h actual %h", e.pos_x, d[31:0]);
				errors++;
			end
			if (d[63:32] !== e.pos_y) begin
				$error("pos_y expected %h actual %h", e.pos_y, d[63:32]);
				errors++;
			end
			if (d[79:64] !== e.heading) begin
				$error("heading expected %h actual %h", e.heading, d[79:64]);
				errors++;
			end
			if (d[111:80] !== e.remaining) begin
				$error("remaining expected %h actual %h", e.remaining, d[111:80]);
				errors++;
			end
			if (user !== e.arrived) begin
				$error("arrived expected %0b actual %0b", e.arrived, user);
				errors++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic                          cfg_index;
	logic [pst_pkg::SPEED_W-1:0]   cfg_data;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [63:0]                   s_tdata;   // goal_x, goal_y
	logic                          m_tvalid;
	logic                          m_tready;
	logic [111:0]                  m_tdata;   // pos_x, pos_y, heading, remaining
	logic                          m_tuser;   // arrived

	pose_scoreboard sb;
	int gap_pct, stall_pct, hold_left, cycles;

	pose_step_toward_target uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver ready: long hold when asked, random stalls otherwise
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// result beat monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// one register write, with the write enable low again before the task returns
	task automatic write_cfg(logic idx, logic [pst_pkg::SPEED_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	// one target beat, entered and left at a falling edge
	task automatic send_target(logic [31:0] tx, logic [31:0] ty);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {ty, tx};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_target(tx, ty);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// half the targets near the pose, a tenth identical, the rest anywhere
	task automatic send_random_target();
		int pick, sh;
		logic [31:0] ox, oy;
		pick = $urandom_range(9);
		sh = $urandom_range(24);
		ox = $urandom() >> (31 - sh);
		oy = $urandom() >> (31 - sh);
		if ($urandom_range(1)) ox = -ox;
		if ($urandom_range(1)) oy = -oy;
		if (pick < 5)
			send_target(sb.pose_x[31:0] + ox, sb.pose_y[31:0] + oy);
		else if (pick == 5)
			send_target(sb.pose_x[31:0], sb.pose_y[31:0]);
		else
			send_target($urandom(), $urandom());
	endtask

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 50; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 50; end
			default: begin gap_pct = 22; stall_pct = 22; end
		endcase
	endtask

	initial begin
		logic [pst_pkg::SPEED_W-1:0] spd_set[8];
		logic [pst_pkg::TSTEP_W-1:0] ts_set[8];
		sb = new();
		hold_left = 0;
		gap_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pst_pkg::REG_SPEED;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero offset, snaps, axis and quadrant headings, field extremes
		send_target(32'd0, 32'd0);
		send_target(32'd100, 32'd0);
		send_target(32'd100, -32'sd100);
		send_target(-32'sd1000, 32'd0);
		send_target(-32'sd1000, -32'sd5);
		send_target(32'd0, 32'd0);
		send_target(32'h7FFF_FFFF, 32'd0);
		send_target(32'h8000_0000, 32'd0);
		send_target(32'd0, 32'h7FFF_FFFF);
		send_target(32'h7FFF_FFFF, 32'h8000_0000);
		send_target(32'h8000_0000, 32'h7FFF_FFFF);
		send_target(32'h8000_0000, 32'h8000_0000);
		send_target(sb.pose_x[31:0], sb.pose_y[31:0]);
		send_target(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_target(32'h5555_5555, 32'hAAAA_AAAA);
		drain();

		// largest step: run to a corner, then across for a saturated distance
		write_cfg(pst_pkg::REG_SPEED, 24'hFF_FFFF);
		write_cfg(pst_pkg::REG_TSTEP, 24'h00_FFFF);
		set_idling(3);
		for (int i = 0; i < 190; i++)
			send_target(32'h8000_0000, 32'h8000_0000);
		send_target(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_target(32'h7FFF_FFFF, 32'h8000_0000);
		send_target(32'h8000_0000, 32'h7FFF_FFFF);
		send_target(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		drain();

		// random phases under several register settings
		spd_set = '{24'd0, 24'd32768, 24'hFF_FFFF, 24'd1, 24'd0, 24'd0, 24'd0, 24'd0};
		ts_set  = '{16'd3277, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0};
		for (int p = 4; p < 8; p++) begin
			spd_set[p] = pst_pkg::SPEED_W'($urandom_range(24'hFF_FFFF >> (4 * (p - 4))));
			ts_set[p] = pst_pkg::TSTEP_W'($urandom_range(16'hFFFF));
		end
		for (int p = 0; p < 8; p++) begin
			write_cfg(pst_pkg::REG_SPEED, spd_set[p]);
			write_cfg(pst_pkg::REG_TSTEP, {8'd0, ts_set[p]});
			set_idling(p);
			if (p == 5) begin
				@(posedge clk);
				hold_left = 400;
				@(negedge clk);
			end
			for (int i = 0; i < 120; i++)
				send_random_target();
			drain();
		end

		$display("covered %0d targets, %0d results: %0d snapped, %0d moved, %0d unchanged",
			sb.targets_seen, sb.results_seen, sb.snaps, sb.moves, sb.stays);
		$display("saturated distances %0d, over eight register settings and four idling mixes",
			sb.saturated);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> pose_step_toward_target.f
rtl/pst_pkg.sv
rtl/pst_ctrl.sv
rtl/pst_dp.sv
rtl/pose_step_toward_target.sv
tb/sv/pose_step_toward_target_test.sv
